@@ rtl/spq_pkg.sv @@
// Package for the sorted priority queue: sizes, command and status codes,
// payload structs and the sequencer state type. No dependencies.
`default_nettype none

package spq_pkg;

    // Storage sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Command codes (kind field)
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  new_priority;
        logic [15:0] new_tag;
        logic [4:0]  position;
    } spq_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_priority;
        logic [15:0] out_tag;
        logic [4:0]  entry_count;
    } spq_out_t;

    // One stored slot
    typedef struct packed {
        logic [7:0]  priority_val;
        logic [15:0] tag;
    } spq_entry_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_DONE
    } spq_state_t;

endpackage

`default_nettype wire

@@ rtl/spq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
// Sorted priority queue top level: command sequencer, slot scan and result
// register. Depends on spq_pkg and spq_ram.
//
// Usage:
//   Commands enter on the s_ channel (s_valid/s_ready, payload s_data) and
//   each gives exactly one result on the m_ channel (m_valid/m_ready,
//   payload m_data). Kinds: insert, pop head, update tag at a 1-based
//   position. Entries sit in one slot RAM in descending priority order.
//   A command that walks the slots streams through the RAM one slot per
//   cycle. Refused commands (full, empty, position not found) and the
//   unused kind skip the slot walk. A new command is taken once the
//   previous one has reached the result register.
//   Reset (aresetn low, synchronous) empties the queue and drops any
//   pending result; slot contents are not cleared.
//   When the receiver stalls, the result holds in the output register and
//   one more command may run; its result waits until the register frees.
`default_nettype none

module sorted_priority_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire spq_pkg::spq_in_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output spq_pkg::spq_out_t    m_data
);

    // Sequencer and command state
    spq_pkg::spq_state_t          state_reg, state_next;
    spq_pkg::spq_in_t             cmd_reg, cmd_next;
    logic [spq_pkg::CNT_W-1:0]    count_reg, count_next;

    // Read issue side of the scan
    logic [spq_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic [spq_pkg::ADDR_W-1:0]   last_reg, last_next;
    logic                         issue_reg, issue_next;

    // Processing side, aligned with the registered read data
    logic                         p_valid_reg, p_valid_next;
    logic [spq_pkg::ADDR_W-1:0]   p_idx_reg, p_idx_next;
    logic                         p_last_reg, p_last_next;
    logic                         placed_reg, placed_next;
    spq_pkg::spq_entry_t          carry_reg, carry_next;

    // Result being built and output register
    logic [1:0]                   res_status_reg, res_status_next;
    logic [7:0]                   res_pri_reg, res_pri_next;
    logic [15:0]                  res_tag_reg, res_tag_next;
    logic                         m_valid_reg, m_valid_next;
    spq_pkg::spq_out_t            m_data_reg, m_data_next;

    // RAM port signals
    logic                         wr_en;
    logic [spq_pkg::ADDR_W-1:0]   wr_addr;
    spq_pkg::spq_entry_t          wr_data;
    spq_pkg::spq_entry_t          rd_data;

    // Command decode at transfer
    logic                         accept;
    logic                         start_scan;
    logic [1:0]                   start_status;
    logic [spq_pkg::ADDR_W-1:0]   start_idx;
    logic [spq_pkg::ADDR_W-1:0]   start_last;
    logic                         scan_done;
    logic                         out_free;
    logic [31:0]                  pos_m1;
    logic [spq_pkg::CNT_W-1:0]    count_m1;
    logic [31:0]                  count_wide;

    spq_ram #(
        .WIDTH ($bits(spq_pkg::spq_entry_t)),
        .DEPTH (spq_pkg::QUEUE_DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign accept    = s_valid && s_ready;
    assign scan_done = p_valid_reg && p_last_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign pos_m1    = 32'(s_data.position) - 32'd1;
    assign count_m1  = count_reg - 1'b1;

    // Decode the incoming command: refuse early, skip the scan for the unused kind, or set up the scan range
    always_comb begin
        start_scan   = 1'b0;
        start_status = spq_pkg::ST_OK;
        start_idx    = '0;
        start_last   = '0;
        unique case (s_data.kind)
            spq_pkg::KIND_INSERT: begin
                if (count_reg == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH)) begin
                    start_status = spq_pkg::ST_FULL;
                end else begin
                    start_scan = 1'b1;
                    start_last = count_reg[spq_pkg::ADDR_W-1:0];
                end
            end
            spq_pkg::KIND_POP: begin
                if (count_reg == '0) begin
                    start_status = spq_pkg::ST_EMPTY;
                end else begin
                    start_scan = 1'b1;
                    start_last = count_m1[spq_pkg::ADDR_W-1:0];
                end
            end
            spq_pkg::KIND_UPDATE: begin
                if (s_data.position == '0 ||
                    32'(s_data.position) > 32'(count_reg)) begin
                    start_status = spq_pkg::ST_NOTFOUND;
                end else begin
                    start_scan = 1'b1;
                    start_idx  = pos_m1[spq_pkg::ADDR_W-1:0];
                    start_last = pos_m1[spq_pkg::ADDR_W-1:0];
                end
            end
            default: begin
                start_status = spq_pkg::ST_OK;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::SEQ_IDLE: begin
                if (accept) begin
                    state_next = start_scan ? spq_pkg::SEQ_SCAN : spq_pkg::SEQ_DONE;
                end
            end
            spq_pkg::SEQ_SCAN: begin
                if (scan_done) begin
                    state_next = spq_pkg::SEQ_DONE;
                end
            end
            spq_pkg::SEQ_DONE: begin
                if (out_free) begin
                    state_next = spq_pkg::SEQ_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready = (state_reg == spq_pkg::SEQ_IDLE);
    end

    // Scan datapath: read issue, insert/pop/update processing, result load
    always_comb begin
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        issue_next      = issue_reg;
        p_valid_next    = 1'b0;
        p_idx_next      = idx_reg;
        p_last_next     = 1'b0;
        placed_next     = placed_reg;
        carry_next      = carry_reg;
        res_status_next = res_status_reg;
        res_pri_next    = res_pri_reg;
        res_tag_next    = res_tag_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        wr_en           = 1'b0;
        wr_addr         = p_idx_reg;
        wr_data         = carry_reg;
        count_wide      = '0;

        // Command transfer
        if (accept) begin
            cmd_next        = s_data;
            placed_next     = 1'b0;
            res_status_next = start_status;
            res_pri_next    = '0;
            res_tag_next    = '0;
            idx_next        = start_idx;
            last_next       = start_last;
            issue_next      = start_scan;
        end

        // Issue one slot read per cycle
        if (state_reg == spq_pkg::SEQ_SCAN && issue_reg) begin
            p_valid_next = 1'b1;
            p_idx_next   = idx_reg;
            p_last_next  = (idx_reg == last_reg);
            if (idx_reg == last_reg) begin
                issue_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end

        // Process the slot whose read data just arrived
        if (p_valid_reg) begin
            unique case (cmd_reg.kind)
                spq_pkg::KIND_INSERT: begin
                    if (placed_reg) begin
                        // ripple the displaced entry one slot toward the tail
                        wr_en      = 1'b1;
                        wr_data    = carry_reg;
                        carry_next = rd_data;
                    end else if (32'(p_idx_reg) == 32'(count_reg) ||
                                 rd_data.priority_val <= cmd_reg.new_priority) begin
                        wr_en                = 1'b1;
                        wr_data.priority_val = cmd_reg.new_priority;
                        wr_data.tag          = cmd_reg.new_tag;
                        placed_next          = 1'b1;
                        carry_next           = rd_data;
                    end
                end
                spq_pkg::KIND_POP: begin
                    if (p_idx_reg == '0) begin
                        res_pri_next = rd_data.priority_val;
                        res_tag_next = rd_data.tag;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = p_idx_reg - 1'b1;
                        wr_data = rd_data;
                    end
                end
                spq_pkg::KIND_UPDATE: begin
                    res_tag_next         = rd_data.tag;
                    wr_en                = 1'b1;
                    wr_data.priority_val = rd_data.priority_val;
                    wr_data.tag          = cmd_reg.new_tag;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end

        // Result register: load when finished and free, drop on transfer
        if (state_reg == spq_pkg::SEQ_DONE && out_free) begin
            if (res_status_reg == spq_pkg::ST_OK &&
                cmd_reg.kind == spq_pkg::KIND_INSERT) begin
                count_next = count_reg + 1'b1;
            end else if (res_status_reg == spq_pkg::ST_OK &&
                         cmd_reg.kind == spq_pkg::KIND_POP) begin
                count_next = count_reg - 1'b1;
            end
            count_wide               = 32'(count_next);
            m_valid_next             = 1'b1;
            m_data_next.status       = res_status_reg;
            m_data_next.out_priority = res_pri_reg;
            m_data_next.out_tag      = res_tag_reg;
            m_data_next.entry_count  = count_wide[4:0];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spq_pkg::SEQ_IDLE;
            count_reg   <= '0;
            issue_reg   <= 1'b0;
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            placed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            p_valid_reg <= p_valid_next;
            p_last_reg  <= p_last_next;
            placed_reg  <= placed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        last_reg       <= last_next;
        p_idx_reg      <= p_idx_next;
        carry_reg      <= carry_next;
        res_status_reg <= res_status_next;
        res_pri_reg    <= res_pri_next;
        res_tag_reg    <= res_tag_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Fill count never goes past the slot count
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(spq_pkg::QUEUE_DEPTH))
        else $error("fill count exceeds queue depth");

    // Slot writes only happen during a scan
    a_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == spq_pkg::SEQ_SCAN))
        else $error("slot write outside scan");

    // The last processed slot ends the scan in the next cycle
    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spq_pkg::SEQ_SCAN && scan_done) |=>
            (state_reg == spq_pkg::SEQ_DONE && !p_valid_reg))
        else $error("scan did not finish after last slot");

endmodule

`default_nettype wire
